@@ design/btt_pkg.sv @@
// Package for the blob track table: payload structs, codes and the state enum.
// No dependencies; used by blob_track_table_top and the testbench.
`timescale 1ns / 1ps
package btt_pkg;
	typedef struct packed {
		logic        req_type;
		logic [15:0] label;
		logic [15:0] centre_x;
		logic [15:0] centre_y;
		logic signed [15:0] speed_x;
		logic signed [15:0] speed_y;
		logic [11:0] box_left;
		logic [11:0] box_top;
		logic [11:0] box_width;
		logic [11:0] box_height;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] out_label;
		logic [15:0] out_centre_x;
		logic [15:0] out_centre_y;
		logic signed [15:0] out_speed_x;
		logic signed [15:0] out_speed_y;
		logic [11:0] out_box_left;
		logic [11:0] out_box_top;
		logic [11:0] out_box_width;
		logic [11:0] out_box_height;
		logic        last;
	} out_beat_t;

	localparam logic [1:0] KIND_DELETE = 2'd0;
	localparam logic [1:0] KIND_UPDATE = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic REQ_DETECT = 1'b0;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MAX_X = 3'd1;
	localparam logic [2:0] REG_MIN_Y = 3'd2;
	localparam logic [2:0] REG_MAX_Y = 3'd3;
	localparam logic [2:0] REG_DIST  = 3'd4;
	localparam logic [2:0] REG_VEL   = 3'd5;
	localparam logic [2:0] REG_FORCE = 3'd6;

	// record: pos 32, motion 32, bounds 48
	localparam int REC_BITS = 112;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_MUL,
		ST_DECIDE,
		ST_CMP_RD,
		ST_CMP_CHK,
		ST_UPD_RD,
		ST_UPD_CHK,
		ST_OUT,
		ST_DONE
	} state_t;
endpackage

@@ design/btt_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module btt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/blob_track_table_top.sv @@
// Top level of the blob track table: sequencer, register file and table RAMs.
// Depends on btt_pkg and btt_ram.
`timescale 1ns / 1ps
// A detection beat walks the table one entry at a time, reading and then
// checking each, looking for its label. A detection outside the window is
// dropped in its accept cycle. One squared-distance multiplier is reused
// four times over a match (dx, dy, vx, vy). An end-of-frame beat runs a
// delete/compact pass over every entry, then an update pass over the kept
// entries, sends a result beat for each deleted or updated entry, holding
// it while the output stalls, and ends with the done beat. Input stall is
// high whenever the sequencer is busy. Labels, records and marks live in
// RAMs with registered reads; marks for entries at or above the count are
// never read, so no clearing pass is needed after reset.
module blob_track_table_top #(
	parameter int MAX_BLOBS  = 32,
	parameter int LABEL_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  btt_pkg::in_beat_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output btt_pkg::out_beat_t                   out_data,
	input  logic                                 cfg_we,
	input  logic [btt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [btt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import btt_pkg::*;

	localparam int AW = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
	localparam int CW = $clog2(MAX_BLOBS + 1);
	localparam int DEPTH = 1 << AW;

	// configuration registers
	logic [15:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [6:0]  dist_q;
	logic [8:0]  vel_q;
	logic        force_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			max_x_q <= 16'hFFFF;
			min_y_q <= '0;
			max_y_q <= 16'hFFFF;
			dist_q  <= 7'd10;
			vel_q   <= 9'd3;
			force_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_X: min_x_q <= cfg_data;
				REG_MAX_X: max_x_q <= cfg_data;
				REG_MIN_Y: min_y_q <= cfg_data;
				REG_MAX_Y: max_y_q <= cfg_data;
				REG_DIST:  dist_q  <= cfg_data[6:0];
				REG_VEL:   vel_q   <= cfg_data[8:0];
				REG_FORCE: force_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer state
	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;     // read pointer
	logic [CW-1:0] keep_q;   // compaction write pointer
	logic [1:0]    mstep_q;  // multiplier step
	logic [34:0]   acc_q;    // d2 sum (bits 33:0 sufficient, 35 kept for v2 too)
	logic [34:0]   accv_q;
	logic          out_kind_upd_q;
	in_beat_t      req_q;
	logic          window_ok;

	// RAM ports
	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [LABEL_BITS-1:0] lab_wd, lab_rd;
	logic [REC_BITS-1:0]   rec_wd, rec_rd;
	logic [1:0]            mk_wd, mk_rd;
	logic                  lab_we, rec_we;

	btt_ram #(.WIDTH(LABEL_BITS), .DEPTH(DEPTH)) u_lab (
		.clk(clk), .we(lab_we), .waddr(waddr), .wdata(lab_wd),
		.raddr(raddr), .rdata(lab_rd));
	btt_ram #(.WIDTH(REC_BITS), .DEPTH(DEPTH)) u_rec (
		.clk(clk), .we(rec_we), .waddr(waddr), .wdata(rec_wd),
		.raddr(raddr), .rdata(rec_rd));
	btt_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_mk (
		.clk(clk), .we(we), .waddr(waddr), .wdata(mk_wd),
		.raddr(raddr), .rdata(mk_rd));

	logic [LABEL_BITS-1:0] req_lab;
	logic [REC_BITS-1:0]   req_rec;
	assign req_lab = LABEL_BITS'(req_q.label);
	assign req_rec = {req_q.box_height, req_q.box_width, req_q.box_top, req_q.box_left,
		req_q.speed_y, req_q.speed_x, req_q.centre_y, req_q.centre_x};

	// record fields from RAM
	logic [15:0] r_cx, r_cy, r_vx, r_vy;
	assign r_cx = rec_rd[15:0];
	assign r_cy = rec_rd[31:16];
	assign r_vx = rec_rd[47:32];
	assign r_vy = rec_rd[63:48];

	// shared squaring unit: one 17-bit signed difference squared per cycle
	logic signed [16:0] diff;
	logic [15:0]        mag;
	logic [31:0]        sq_mag;
	logic [33:0]        sq;
	always_comb begin
		case (mstep_q)
			2'd0: diff = $signed({1'b0, req_q.centre_x}) - $signed({1'b0, r_cx});
			2'd1: diff = $signed({1'b0, req_q.centre_y}) - $signed({1'b0, r_cy});
			2'd2: diff = $signed({req_q.speed_x[15], req_q.speed_x})
				- $signed({r_vx[15], r_vx});
			default: diff = $signed({req_q.speed_y[15], req_q.speed_y})
				- $signed({r_vy[15], r_vy});
		endcase
	end
	// square the magnitude; it never exceeds 65535
	assign mag = diff[16] ? 16'(-diff) : diff[15:0];
	assign sq_mag = mag * mag;
	assign sq = {2'b00, sq_mag};

	logic [10:0] dt;
	logic [21:0] dt2;
	logic [17:0] vt2;
	logic        refresh;
	assign dt  = {dist_q, 4'b0};
	assign dt2 = dt * dt;
	assign vt2 = vel_q * vel_q;
	assign refresh = force_q || (acc_q > 35'(dt2)) || (accv_q > 35'(vt2));

	assign window_ok = (in_data.centre_x > min_x_q) && (in_data.centre_x < max_x_q)
		&& (in_data.centre_y > min_y_q) && (in_data.centre_y < max_y_q);

	logic rd_end;
	assign rd_end = (rd_q >= count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.req_type != REQ_DETECT) state_d = ST_CMP_RD;
					else if (window_ok) state_d = ST_SRCH_RD;
				end
			end
			ST_SRCH_RD: state_d = rd_end ? ST_DECIDE : ST_SRCH_CHK;
			ST_SRCH_CHK: state_d = (lab_rd == req_lab) ? ST_MUL : ST_SRCH_RD;
			ST_MUL: if (mstep_q == 2'd3) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_IDLE;
			ST_CMP_RD: state_d = rd_end ? ST_UPD_RD : ST_CMP_CHK;
			ST_CMP_CHK: state_d = mk_rd[0] ? ST_CMP_RD : ST_OUT;
			ST_UPD_RD: state_d = rd_end ? ST_DONE : ST_UPD_CHK;
			ST_UPD_CHK: state_d = mk_rd[1] ? ST_OUT : ST_UPD_RD;
			ST_OUT: if (!out_stall) state_d = out_kind_upd_q ? ST_UPD_RD : ST_CMP_RD;
			ST_DONE: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and RAM controls
	logic [CW-1:0] hit_q;
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT) || (state_q == ST_DONE);
		raddr  = rd_q[AW-1:0];
		we     = 1'b0;
		lab_we = 1'b0;
		rec_we = 1'b0;
		waddr  = keep_q[AW-1:0];
		lab_wd = lab_rd;
		rec_wd = rec_rd;
		mk_wd  = mk_rd;
		unique case (state_q)
			ST_SRCH_CHK: begin
				// hold the entry under test on the read port
				raddr = rd_q[AW-1:0] - 1'b1;
			end
			ST_MUL: begin
				// keep the matched entry on the read port through the squares
				raddr = hit_q[AW-1:0];
			end
			ST_DECIDE: begin
				if (hit_q < count_q) begin
					waddr = hit_q[AW-1:0];
					we = 1'b1;
					mk_wd = {refresh | mk_rd[1], 1'b1};
					rec_we = refresh;
					rec_wd = req_rec;
				end else if (count_q < CW'(MAX_BLOBS)) begin
					waddr = count_q[AW-1:0];
					we = 1'b1;
					lab_we = 1'b1;
					rec_we = 1'b1;
					lab_wd = req_lab;
					rec_wd = req_rec;
					mk_wd = 2'b11;
				end
			end
			ST_CMP_CHK: begin
				// compact found entries down to keep
				if (mk_rd[0]) begin
					we = 1'b1;
					lab_we = 1'b1;
					rec_we = 1'b1;
				end
			end
			ST_UPD_CHK: begin
				waddr = rd_q[AW-1:0] - 1'b1;
				we = 1'b1;
				mk_wd = 2'b00;
			end
			default: ;
		endcase
	end

	// output payload; held in registers while stalled
	out_beat_t ob_q;
	assign out_data = ob_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP_CHK && !mk_rd[0]) begin
			ob_q <= '{kind: KIND_DELETE, out_label: 16'(lab_rd), default: '0};
		end else if (state_q == ST_UPD_CHK && mk_rd[1]) begin
			ob_q <= '{kind: KIND_UPDATE,
				out_label: 16'(lab_rd),
				out_centre_x: rec_rd[15:0],
				out_centre_y: rec_rd[31:16],
				out_speed_x: $signed(rec_rd[47:32]),
				out_speed_y: $signed(rec_rd[63:48]),
				out_box_left: rec_rd[75:64],
				out_box_top: rec_rd[87:76],
				out_box_width: rec_rd[99:88],
				out_box_height: rec_rd[111:100],
				last: 1'b0};
		end else if (state_q == ST_UPD_RD && rd_end) begin
			ob_q <= '{kind: KIND_DONE, last: 1'b1, default: '0};
		end
		if (state_q == ST_IDLE && in_valid) begin
			req_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_q <= '0;
			keep_q <= '0;
			hit_q <= '0;
			mstep_q <= '0;
			acc_q <= '0;
			accv_q <= '0;
			out_kind_upd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					rd_q <= '0;
					keep_q <= '0;
					mstep_q <= '0;
					acc_q <= '0;
					accv_q <= '0;
					hit_q <= count_q;
					out_kind_upd_q <= 1'b0;
				end
				ST_SRCH_RD: rd_q <= rd_q + 1'b1;
				ST_SRCH_CHK: if (lab_rd == req_lab) hit_q <= rd_q - 1'b1;
				ST_MUL: begin
					// read port holds the matched entry
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q[1]) accv_q <= accv_q + 35'(sq);
					else acc_q <= acc_q + 35'(sq);
				end
				ST_DECIDE: begin
					if (hit_q >= count_q && count_q < CW'(MAX_BLOBS))
						count_q <= count_q + 1'b1;
				end
				ST_CMP_RD: begin
					if (rd_end) begin
						count_q <= keep_q;
						rd_q <= '0;
						out_kind_upd_q <= 1'b1;
					end else begin
						rd_q <= rd_q + 1'b1;
					end
				end
				ST_CMP_CHK: if (mk_rd[0]) keep_q <= keep_q + 1'b1;
				ST_UPD_RD: if (!rd_end) rd_q <= rd_q + 1'b1;
				default: ;
			endcase
		end
	end
endmodule

@@ tb/tb_blob_track_table_top.sv @@
// Testbench for blob_track_table_top: directed and random detection and
// end-of-frame beats, scored against a table model kept in the bench.
// Depends on btt_pkg and the design sources.
`timescale 1ns / 1ps
module tb_blob_track_table_top;
	import btt_pkg::*;

	localparam int TABLE_SIZE = 32;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	out_beat_t out_data;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	blob_track_table_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Bench copy of the registers and the table.
	logic [15:0] win_min_x, win_max_x, win_min_y, win_max_y;
	logic [6:0] move_limit;
	logic [8:0] speed_limit;
	logic always_refresh;
	int n_tracks;
	logic [15:0] trk_label [TABLE_SIZE];
	logic [15:0] trk_cx [TABLE_SIZE], trk_cy [TABLE_SIZE];
	logic [15:0] trk_vx [TABLE_SIZE], trk_vy [TABLE_SIZE];
	logic [11:0] trk_l [TABLE_SIZE], trk_t [TABLE_SIZE];
	logic [11:0] trk_w [TABLE_SIZE], trk_h [TABLE_SIZE];
	logic trk_found [TABLE_SIZE], trk_dirty [TABLE_SIZE];

	out_beat_t pending_reports[$];
	int errors;
	longint cycles;
	logic [15:0] live_labels[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: far above the slowest legal run.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 2000000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver: random stall, long now and then, with quiet stretches.
	initial begin
		int gap;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (cycles % 3000 < 600) begin
				out_stall <= 1'b0;
			end else begin
				gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
				if (gap != 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
				out_stall <= 1'b0;
			end
		end
	end

	// Check each accepted result beat against the oldest expected one.
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t unexpected result beat, expected none, actual %p", $time, out_data);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (out_data !== want) begin
					$display("%0t mismatch: expected %p, actual %p", $time, want, out_data);
					errors++;
				end
			end
		end
	end

	function automatic out_beat_t track_report(logic [1:0] kind, int i);
		out_beat_t r;
		r = '0;
		r.kind = kind;
		if (kind == KIND_DONE) begin
			r.last = 1'b1;
			return r;
		end
		r.out_label = trk_label[i];
		if (kind == KIND_UPDATE) begin
			r.out_centre_x = trk_cx[i];
			r.out_centre_y = trk_cy[i];
			r.out_speed_x = trk_vx[i];
			r.out_speed_y = trk_vy[i];
			r.out_box_left = trk_l[i];
			r.out_box_top = trk_t[i];
			r.out_box_width = trk_w[i];
			r.out_box_height = trk_h[i];
		end
		return r;
	endfunction

	function automatic void store_track(int i, in_beat_t b);
		trk_cx[i] = b.centre_x;
		trk_cy[i] = b.centre_y;
		trk_vx[i] = b.speed_x;
		trk_vy[i] = b.speed_y;
		trk_l[i] = b.box_left;
		trk_t[i] = b.box_top;
		trk_w[i] = b.box_width;
		trk_h[i] = b.box_height;
	endfunction

	// Advance the table by one beat and queue the results it causes.
	function automatic void track_predict(in_beat_t b);
		longint dx, dy, vx, vy, lim_d, lim_v;
		int keep;
		if (b.req_type != REQ_DETECT) begin
			keep = 0;
			for (int i = 0; i < n_tracks; i++) begin
				if (!trk_found[i]) begin
					pending_reports.push_back(track_report(KIND_DELETE, i));
				end else begin
					trk_label[keep] = trk_label[i];
					trk_cx[keep] = trk_cx[i];
					trk_cy[keep] = trk_cy[i];
					trk_vx[keep] = trk_vx[i];
					trk_vy[keep] = trk_vy[i];
					trk_l[keep] = trk_l[i];
					trk_t[keep] = trk_t[i];
					trk_w[keep] = trk_w[i];
					trk_h[keep] = trk_h[i];
					trk_found[keep] = trk_found[i];
					trk_dirty[keep] = trk_dirty[i];
					keep++;
				end
			end
			n_tracks = keep;
			for (int i = 0; i < n_tracks; i++) begin
				if (trk_dirty[i])
					pending_reports.push_back(track_report(KIND_UPDATE, i));
				trk_found[i] = 1'b0;
				trk_dirty[i] = 1'b0;
			end
			pending_reports.push_back(track_report(KIND_DONE, 0));
			return;
		end
		if (!(b.centre_x > win_min_x && b.centre_x < win_max_x &&
		      b.centre_y > win_min_y && b.centre_y < win_max_y))
			return;
		for (int i = 0; i < n_tracks; i++) begin
			if (trk_label[i] == b.label) begin
				dx = longint'(b.centre_x) - longint'(trk_cx[i]);
				dy = longint'(b.centre_y) - longint'(trk_cy[i]);
				vx = longint'(b.speed_x) - longint'($signed(trk_vx[i]));
				vy = longint'(b.speed_y) - longint'($signed(trk_vy[i]));
				lim_d = longint'(move_limit) * 16;
				lim_v = longint'(speed_limit);
				trk_found[i] = 1'b1;
				if (always_refresh || dx * dx + dy * dy > lim_d * lim_d ||
				    vx * vx + vy * vy > lim_v * lim_v) begin
					store_track(i, b);
					trk_dirty[i] = 1'b1;
				end
				return;
			end
		end
		if (n_tracks >= TABLE_SIZE)
			return;
		trk_label[n_tracks] = b.label;
		store_track(n_tracks, b);
		trk_found[n_tracks] = 1'b1;
		trk_dirty[n_tracks] = 1'b1;
		live_labels.push_back(b.label);
		n_tracks++;
	endfunction

	// Send one beat, with a random gap before it, and hold until accepted.
	// Valid stays up after the accept; the next beat or drain replaces it.
	task automatic send_beat(in_beat_t b);
		int gap;
		gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if (cycles % 4000 < 800)
			gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= b;
		in_valid <= 1'b1;
		track_predict(b);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_MIN_X: win_min_x = val;
			REG_MAX_X: win_max_x = val;
			REG_MIN_Y: win_min_y = val;
			REG_MAX_Y: win_max_y = val;
			REG_DIST: move_limit = val[6:0];
			REG_VEL: speed_limit = val[8:0];
			REG_FORCE: always_refresh = val[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] x0, logic [15:0] x1, logic [15:0] y0,
			logic [15:0] y1, logic [15:0] d, logic [15:0] v, logic [15:0] f);
		drain();
		write_reg(REG_MIN_X, x0);
		write_reg(REG_MAX_X, x1);
		write_reg(REG_MIN_Y, y0);
		write_reg(REG_MAX_Y, y1);
		write_reg(REG_DIST, d);
		write_reg(REG_VEL, v);
		write_reg(REG_FORCE, f);
		cfg_we <= 1'b0;
	endtask

	function automatic in_beat_t blob_beat(logic [15:0] lab);
		in_beat_t b;
		b = '0;
		b.req_type = REQ_DETECT;
		b.label = lab;
		b.centre_x = 16'($urandom);
		b.centre_y = 16'($urandom);
		b.speed_x = 16'($urandom);
		b.speed_y = 16'($urandom);
		b.box_left = 12'($urandom);
		b.box_top = 12'($urandom);
		b.box_width = 12'($urandom);
		b.box_height = 12'($urandom);
		return b;
	endfunction

	function automatic in_beat_t frame_end();
		in_beat_t b;
		b = blob_beat(16'($urandom));
		b.req_type = ~REQ_DETECT;
		return b;
	endfunction

	// Extremes of every field, window edges, empty window, forced refresh.
	task automatic test_directed;
		in_beat_t b;
		b = blob_beat(16'hFFFF);
		b.centre_x = 16'd1; b.centre_y = 16'hFFFE;
		b.speed_x = 16'sh8000; b.speed_y = 16'sh7FFF;
		b.box_left = '1; b.box_top = '0; b.box_width = '1; b.box_height = '0;
		send_beat(b);
		b.label = 16'h0000;
		b.centre_x = 16'hFFFE; b.centre_y = 16'd1;
		b.speed_x = 16'sh7FFF; b.speed_y = 16'sh8000;
		b.box_left = '0; b.box_top = '1; b.box_width = '0; b.box_height = '1;
		send_beat(b);
		// on the edge: dropped
		b.label = 16'h1234; b.centre_x = 16'd0;
		send_beat(b);
		b.centre_x = 16'hFFFF;
		send_beat(b);
		// repeated label, tiny move: found but no refresh
		b = blob_beat(16'hFFFF);
		b.centre_x = 16'd1; b.centre_y = 16'hFFFE;
		b.speed_x = 16'sh8000; b.speed_y = 16'sh7FFF;
		send_beat(b);
		send_beat(frame_end());
		send_beat(frame_end());
		set_regs(16'd100, 16'd100, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd1);
		send_beat(blob_beat(16'd7));
		send_beat(frame_end());
		set_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd1);
		send_beat(blob_beat(16'd7));
		send_beat(blob_beat(16'd7));
		send_beat(frame_end());
	endtask

	// Fill past the table size, then end the frame.
	task automatic test_full_table;
		for (int i = 0; i < TABLE_SIZE + 3; i++)
			send_beat(blob_beat(16'd500 + 16'(i)));
		send_beat(frame_end());
		send_beat(frame_end());
	endtask

	// Frames of detections mostly reusing live labels with small motion.
	task automatic test_random_frames(int n_beats);
		in_beat_t b;
		int sent;
		logic [15:0] lab;
		sent = 0;
		while (sent < n_beats) begin
			if ($urandom_range(0, 7) == 0) begin
				send_beat(frame_end());
				live_labels.delete();
				for (int i = 0; i < n_tracks; i++) live_labels.push_back(trk_label[i]);
			end else begin
				if (live_labels.size() != 0 && $urandom_range(0, 3) != 0)
					lab = live_labels[$urandom_range(0, live_labels.size() - 1)];
				else
					lab = 16'($urandom_range(0, 40));
				b = blob_beat(lab);
				for (int i = 0; i < n_tracks; i++)
					if (trk_label[i] == lab && $urandom_range(0, 2) != 0) begin
						b.centre_x = trk_cx[i] + 16'($urandom_range(0, 400)) - 16'd200;
						b.centre_y = trk_cy[i] + 16'($urandom_range(0, 400)) - 16'd200;
						b.speed_x = trk_vx[i] + 16'($urandom_range(0, 8)) - 16'd4;
						b.speed_y = trk_vy[i] + 16'($urandom_range(0, 8)) - 16'd4;
					end
				send_beat(b);
			end
			sent++;
		end
		send_beat(frame_end());
	endtask

	initial begin
		errors = 0;
		n_tracks = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		win_min_x = 16'd0; win_max_x = 16'hFFFF;
		win_min_y = 16'd0; win_max_y = 16'hFFFF;
		move_limit = 7'd10; speed_limit = 9'd3; always_refresh = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		set_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd10, 16'd3, 16'd0);
		test_random_frames(90);
		set_regs(16'd8000, 16'd60000, 16'd2000, 16'd50000, 16'd80, 16'd256, 16'd0);
		test_random_frames(60);
		set_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd127, 16'h1FF, 16'd0);
		test_random_frames(40);
		set_regs(16'd1, 16'hFFFE, 16'd1, 16'hFFFE, 16'd1, 16'd0, 16'd0);
		test_random_frames(40);
		drain();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
design/btt_pkg.sv
design/btt_ram.sv
design/blob_track_table_top.sv
tb/tb_blob_track_table_top.sv
